// ===== rtl/mouse_motion_button_tracker_unit_defines.svh =====
// Assertion macros for the mouse motion and button tracker.
// Each assertion is clocked on clk_i and is switched off while rst_ni is low.
// Synthesis sees empty bodies.
`ifndef MOUSE_MOTION_BUTTON_TRACKER_UNIT_DEFINES_SVH
`define MOUSE_MOTION_BUTTON_TRACKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication: whenever a holds, c holds as well.
`define MMBT_ASSERT_IMPLY(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error(msg);

// Next-cycle implication: whenever a holds, c holds in the following cycle.
`define MMBT_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error(msg);

`else

`define MMBT_ASSERT_IMPLY(lbl, a, c, msg)
`define MMBT_ASSERT_NEXT(lbl, a, c, msg)

`endif

`endif

// ===== rtl/mmbt_pkg.sv =====
package mmbt_pkg;

  // Field and datapath widths.
  localparam int COORD_W   = 16;  // positions, mickeys, accumulators
  localparam int RATIO_W   = 15;  // mickey ratio registers
  localparam int MASK_W    = 9;   // event bits and report mask
  localparam int BTN_W     = 3;   // button bits of one report
  localparam int WHEEL_W   = 8;   // wheel step
  localparam int FUNC_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int SQ_W      = 17;  // operand of the shared squarer
  localparam int PROD_W    = 2 * SQ_W;
  localparam int ENERGY_W  = 32;
  // Scaled move plus remainder: a doubled move times eight, plus a remainder
  // below the largest ratio, stays well inside 21 signed bits.
  localparam int TERM_W    = 21;
  // Position plus quotient before the window clamp.
  localparam int POS_W     = 22;
  localparam int WHERE_W   = 2 * COORD_W;
  localparam int BTN_EV_W  = MASK_W - 1;  // button event bits above the move bit

  // Algorithm constants.
  localparam int TICK_WINDOW = 18;
  localparam int SCALE_SHIFT = 3;   // times eight
  localparam int BUTTON_COUNT_DEF = 3;
  localparam logic WHEEL_PRESENT = 1'b1;

  // Event bit positions.
  localparam int EV_MOVE  = 0;
  localparam int EV_WHEEL = 7;
  localparam int EV_ABS   = 8;

  // Register reset values.
  localparam logic [RATIO_W-1:0]        RATIO_X_RST = RATIO_W'(8);
  localparam logic [RATIO_W-1:0]        RATIO_Y_RST = RATIO_W'(16);
  localparam logic [COORD_W-1:0]        LIMIT_RST   = COORD_W'(64);
  localparam logic signed [COORD_W-1:0] LEFT_RST    = COORD_W'(0);
  localparam logic signed [COORD_W-1:0] RIGHT_RST   = COORD_W'(639);
  localparam logic signed [COORD_W-1:0] TOP_RST     = COORD_W'(0);
  localparam logic signed [COORD_W-1:0] BOTTOM_RST  = COORD_W'(199);
  localparam logic [MASK_W-1:0]         MASK_RST    = MASK_W'(0);

  // Operation codes of an input transaction.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_REPORT   = 3'd0,
    FUNC_SET_POS  = 3'd1,
    FUNC_RD_PRESS = 3'd2,
    FUNC_RD_REL   = 3'd3,
    FUNC_RD_MOVE  = 3'd4
  } func_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATIO_X = 3'd0,
    CFG_RATIO_Y = 3'd1,
    CFG_LIMIT   = 3'd2,
    CFG_LEFT    = 3'd3,
    CFG_RIGHT   = 3'd4,
    CFG_TOP     = 3'd5,
    CFG_BOTTOM  = 3'd6,
    CFG_MASK    = 3'd7
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SQX,
    S_SQY,
    S_LIM,
    S_CMP,
    S_DIVX,
    S_DIVY,
    S_FINISH
  } state_e;

  // Control from the sequencer to the button counter bank.
  typedef struct packed {
    logic upd;       // count the edges of this report
    logic rd_press;  // read and clear the selected press counter
    logic rd_rel;    // read and clear the selected release counter
  } btn_ctl_t;

  // Clamp to the window: the minimum first, then the maximum.
  function automatic logic signed [COORD_W-1:0] clamp_edge(
    input logic signed [POS_W-1:0]   p,
    input logic signed [COORD_W-1:0] lo,
    input logic signed [COORD_W-1:0] hi
  );
    logic signed [POS_W-1:0] lo_w;
    logic signed [POS_W-1:0] hi_w;
    logic signed [POS_W-1:0] r;
    lo_w = {{(POS_W-COORD_W){lo[COORD_W-1]}}, lo};
    hi_w = {{(POS_W-COORD_W){hi[COORD_W-1]}}, hi};
    r = p;
    if (r < lo_w) r = lo_w;
    if (r > hi_w) r = hi_w;
    return r[COORD_W-1:0];
  endfunction

endpackage

// ===== rtl/mouse_motion_button_tracker_unit.sv =====
// Mouse motion and button tracker.
// Input channel (in_valid_i/in_ready_o) carries one mouse report or one host
// access per transaction; output channel (out_valid_o/out_ready_i) returns one
// result transaction for each. Configuration writes arrive on cfg_valid_i with
// cfg_index_i and cfg_data_i; cfg_ready_o is always high and writes are meant
// for an idle block.
// Sequence: a relative report with motion squares the motion x, the motion y and
// the threshold in turn on one shared 17x17 squarer, then a restoring divider
// produces one quotient bit per cycle for each axis, x then y. Reports without
// relative motion and host accesses go from S_EXEC straight to S_FINISH, where
// the result is registered once the output register is free.
// One transaction is worked at a time; in_ready_o is high only while the
// sequencer is idle, the cycle after the result has been registered.
// The result sits in an output register: if the receiver stalls, the next
// transaction is still accepted and worked, and its result waits until the
// held one has been taken.
// Reset loads the register defaults, puts the cursor at the top left corner of
// the default window and clears accumulators, counters and the button history.
`include "mouse_motion_button_tracker_unit_defines.svh"

module mouse_motion_button_tracker_unit #(
  parameter int BUTTON_COUNT = mmbt_pkg::BUTTON_COUNT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mmbt_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mmbt_pkg::CFG_W-1:0]           cfg_data_i,
  // Input channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [mmbt_pkg::FUNC_W-1:0]          func_i,
  input  logic [mmbt_pkg::BTN_W-1:0]           btn_in_i,
  input  logic                                 abs_mode_i,
  input  logic signed [mmbt_pkg::COORD_W-1:0]  move_x_i,
  input  logic signed [mmbt_pkg::COORD_W-1:0]  move_y_i,
  input  logic signed [mmbt_pkg::WHEEL_W-1:0]  wheel_step_i,
  input  logic [mmbt_pkg::COORD_W-1:0]         tick_now_i,
  input  logic [mmbt_pkg::BTN_W-1:0]           btn_select_i,
  // Output channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [mmbt_pkg::MASK_W-1:0]          event_bits_o,
  output logic [mmbt_pkg::COORD_W-1:0]         btn_state_out_o,
  output logic signed [mmbt_pkg::COORD_W-1:0]  cur_x_o,
  output logic signed [mmbt_pkg::COORD_W-1:0]  cur_y_o,
  output logic signed [mmbt_pkg::COORD_W-1:0]  motion_x_o,
  output logic signed [mmbt_pkg::COORD_W-1:0]  motion_y_o,
  output logic [mmbt_pkg::COORD_W-1:0]         tally_o,
  output logic signed [mmbt_pkg::COORD_W-1:0]  at_x_o,
  output logic signed [mmbt_pkg::COORD_W-1:0]  at_y_o,
  output logic                                 notify_o
);

  localparam int CW = mmbt_pkg::COORD_W;
  localparam int RW = mmbt_pkg::RATIO_W;
  localparam int TW = mmbt_pkg::TERM_W;
  localparam int PW = mmbt_pkg::POS_W;
  localparam int EW = mmbt_pkg::ENERGY_W;
  localparam int QW = mmbt_pkg::PROD_W;
  localparam int SW = mmbt_pkg::SQ_W;
  localparam int MW = mmbt_pkg::MASK_W;

  // Configuration registers
  logic [RW-1:0]        ratio_x_q, ratio_y_q;
  logic [CW-1:0]        limit_q;
  logic signed [CW-1:0] left_q, right_q, top_q, bottom_q;
  logic [MW-1:0]        mask_q;

  // Captured transaction
  logic [mmbt_pkg::FUNC_W-1:0]  func_q;
  logic [mmbt_pkg::BTN_W-1:0]   btn_q;
  logic                         abs_q;
  logic signed [CW-1:0]         mx_q, my_q;
  logic signed [mmbt_pkg::WHEEL_W-1:0] wheel_q;
  logic [CW-1:0]                tick_q;
  logic [mmbt_pkg::BTN_W-1:0]   sel_q;

  // Tracker state
  logic signed [CW-1:0] pos_x_q, pos_y_q;
  logic signed [CW-1:0] rem_x_q, rem_y_q;
  logic [CW-1:0]        acc_x_q, acc_y_q;
  logic [mmbt_pkg::BTN_W-1:0] prior_q;
  logic [CW-1:0]        tick_mark_q;
  logic [EW-1:0]        energy_q;

  // Working registers
  mmbt_pkg::state_e     state_q, state_d;
  logic [MW-1:0]        ev_q;
  logic                 clamp_q;
  logic signed [PW-1:0] pre_x_q, pre_y_q;
  logic [QW-1:0]        prod_q;
  logic [QW-1:0]        sum_q;
  logic signed [TW-1:0] ty_q;

  // Output registers
  logic                 out_valid_q;
  logic [MW-1:0]        event_bits_q;
  logic [CW-1:0]        btn_state_q;
  logic signed [CW-1:0] cur_x_q, cur_y_q, motion_x_q, motion_y_q;
  logic [CW-1:0]        tally_q;
  logic signed [CW-1:0] at_x_q, at_y_q;
  logic                 notify_q;

  // Sequencer outputs
  logic                 in_fire;
  logic                 fire;
  logic                 div_start;
  mmbt_pkg::btn_ctl_t   bank_ctl;

  // Datapath signals
  mmbt_pkg::func_e      func_cur;
  logic                 is_move;
  logic                 abs_moved;
  logic                 window_over;
  logic [CW-1:0]        tick_gap;
  logic [MW-1:0]        ev_exec;
  logic [CW-1:0]        abs_dx, abs_dy;
  logic [SW-1:0]        ax, ay, sq_op;
  logic [SW-1:0]        mx_ext, my_ext;
  logic [QW-1:0]        energy_sum;
  logic                 doubled;
  logic [SW-1:0]        mx_eff, my_eff;
  logic signed [TW-1:0] tx, ty;
  logic signed [TW-1:0] div_dividend;
  logic [RW-1:0]        div_divisor;
  logic                 div_busy, div_done;
  logic signed [TW-1:0] div_quo;
  logic signed [CW-1:0] div_rem;
  logic signed [CW-1:0] clamp_x, clamp_y;
  logic signed [CW-1:0] new_x, new_y;
  logic [mmbt_pkg::BTN_EV_W-1:0] bank_ev;
  logic [CW-1:0]        bank_tally;
  logic [mmbt_pkg::WHERE_W-1:0]  bank_where;
  logic [MW-1:0]        events;
  logic [mmbt_pkg::WHEEL_W-1:0]  wheel_bits;

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_x_q <= mmbt_pkg::RATIO_X_RST;
      ratio_y_q <= mmbt_pkg::RATIO_Y_RST;
      limit_q   <= mmbt_pkg::LIMIT_RST;
      left_q    <= mmbt_pkg::LEFT_RST;
      right_q   <= mmbt_pkg::RIGHT_RST;
      top_q     <= mmbt_pkg::TOP_RST;
      bottom_q  <= mmbt_pkg::BOTTOM_RST;
      mask_q    <= mmbt_pkg::MASK_RST;
    end else if (cfg_valid_i) begin
      case (mmbt_pkg::cfg_idx_e'(cfg_index_i))
        mmbt_pkg::CFG_RATIO_X: ratio_x_q <= cfg_data_i[RW-1:0];
        mmbt_pkg::CFG_RATIO_Y: ratio_y_q <= cfg_data_i[RW-1:0];
        mmbt_pkg::CFG_LIMIT:   limit_q   <= cfg_data_i;
        mmbt_pkg::CFG_LEFT:    left_q    <= cfg_data_i;
        mmbt_pkg::CFG_RIGHT:   right_q   <= cfg_data_i;
        mmbt_pkg::CFG_TOP:     top_q     <= cfg_data_i;
        mmbt_pkg::CFG_BOTTOM:  bottom_q  <= cfg_data_i;
        mmbt_pkg::CFG_MASK:    mask_q    <= cfg_data_i[MW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  assign func_cur = mmbt_pkg::func_e'(func_q);
  assign is_move  = (mx_q != '0) || (my_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmbt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    fire             = 1'b0;
    div_start        = 1'b0;
    bank_ctl         = '0;
    case (state_q)
      mmbt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = mmbt_pkg::S_EXEC;
      end
      mmbt_pkg::S_EXEC: begin
        if ((func_cur == mmbt_pkg::FUNC_REPORT) && !abs_q && is_move) begin
          state_d = mmbt_pkg::S_SQX;
        end else begin
          state_d = mmbt_pkg::S_FINISH;
        end
      end
      mmbt_pkg::S_SQX: state_d = mmbt_pkg::S_SQY;
      mmbt_pkg::S_SQY: state_d = mmbt_pkg::S_LIM;
      mmbt_pkg::S_LIM: state_d = mmbt_pkg::S_CMP;
      mmbt_pkg::S_CMP: begin
        div_start = 1'b1;
        state_d   = mmbt_pkg::S_DIVX;
      end
      mmbt_pkg::S_DIVX: begin
        if (div_done) begin
          div_start = 1'b1;
          state_d   = mmbt_pkg::S_DIVY;
        end
      end
      mmbt_pkg::S_DIVY: begin
        if (div_done) state_d = mmbt_pkg::S_FINISH;
      end
      mmbt_pkg::S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          fire              = 1'b1;
          bank_ctl.upd      = (func_cur == mmbt_pkg::FUNC_REPORT);
          bank_ctl.rd_press = (func_cur == mmbt_pkg::FUNC_RD_PRESS);
          bank_ctl.rd_rel   = (func_cur == mmbt_pkg::FUNC_RD_REL);
          state_d           = mmbt_pkg::S_IDLE;
        end
      end
      default: state_d = mmbt_pkg::S_IDLE;
    endcase
  end

  assign in_fire = in_valid_i && in_ready_o;

  // Capture the accepted transaction.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q  <= func_i;
      btn_q   <= btn_in_i;
      abs_q   <= abs_mode_i;
      mx_q    <= move_x_i;
      my_q    <= move_y_i;
      wheel_q <= wheel_step_i;
      tick_q  <= tick_now_i;
      sel_q   <= btn_select_i;
    end
  end

  // ---------------------------------------------------------------------
  // First step: absolute placement, event bits, tick window
  // ---------------------------------------------------------------------
  always_comb begin
    tick_gap    = tick_q - tick_mark_q;
    window_over = (tick_gap >= CW'(mmbt_pkg::TICK_WINDOW));
    abs_moved   = (mx_q != pos_x_q) || (my_q != pos_y_q);
    abs_dx      = (mx_q - pos_x_q) << mmbt_pkg::SCALE_SHIFT;
    abs_dy      = (my_q - pos_y_q) << mmbt_pkg::SCALE_SHIFT;
    ev_exec     = '0;
    if (func_cur == mmbt_pkg::FUNC_REPORT) begin
      ev_exec[mmbt_pkg::EV_WHEEL] = mmbt_pkg::WHEEL_PRESENT && (wheel_q != '0);
      if (abs_q) begin
        ev_exec[mmbt_pkg::EV_ABS]  = 1'b1;
        ev_exec[mmbt_pkg::EV_MOVE] = abs_moved;
      end else begin
        ev_exec[mmbt_pkg::EV_MOVE] = is_move;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Shared squarer: motion x, motion y, then the threshold
  // ---------------------------------------------------------------------
  always_comb begin
    mx_ext = {mx_q[CW-1], mx_q};
    my_ext = {my_q[CW-1], my_q};
    ax     = mx_ext[SW-1] ? (SW'(0) - mx_ext) : mx_ext;
    ay     = my_ext[SW-1] ? (SW'(0) - my_ext) : my_ext;
    case (state_q)
      mmbt_pkg::S_SQX: sq_op = ax;
      mmbt_pkg::S_SQY: sq_op = ay;
      default:         sq_op = {1'b0, limit_q};
    endcase
    energy_sum = sum_q + prod_q;
  end

  // Doubling and the scaled terms handed to the divider.
  always_comb begin
    doubled = ({(QW-EW)'(0), energy_q} > prod_q);
    mx_eff  = doubled ? {mx_q, 1'b0} : mx_ext;
    my_eff  = doubled ? {my_q, 1'b0} : my_ext;
    tx = {{(TW-SW-mmbt_pkg::SCALE_SHIFT){mx_eff[SW-1]}}, mx_eff,
          mmbt_pkg::SCALE_SHIFT'(0)}
       + {{(TW-CW){rem_x_q[CW-1]}}, rem_x_q};
    ty = {{(TW-SW-mmbt_pkg::SCALE_SHIFT){my_eff[SW-1]}}, my_eff,
          mmbt_pkg::SCALE_SHIFT'(0)}
       + {{(TW-CW){rem_y_q[CW-1]}}, rem_y_q};
    if (state_q == mmbt_pkg::S_CMP) begin
      div_dividend = tx;
      div_divisor  = ratio_x_q;
    end else begin
      div_dividend = ty_q;
      div_divisor  = ratio_y_q;
    end
  end

  mmbt_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // ---------------------------------------------------------------------
  // Final step: window clamp, buttons, result
  // ---------------------------------------------------------------------
  always_comb begin
    clamp_x    = mmbt_pkg::clamp_edge(pre_x_q, left_q, right_q);
    clamp_y    = mmbt_pkg::clamp_edge(pre_y_q, top_q, bottom_q);
    new_x      = clamp_q ? clamp_x : pos_x_q;
    new_y      = clamp_q ? clamp_y : pos_y_q;
    events     = (ev_q | {bank_ev, 1'b0}) & mask_q;
    wheel_bits = ev_q[mmbt_pkg::EV_WHEEL] ? wheel_q : '0;
  end

  mmbt_button_bank #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_bank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (bank_ctl),
    .btn_i   (btn_q),
    .prior_i (prior_q),
    .where_i ({new_y, new_x}),
    .sel_i   (sel_q),
    .ev_o    (bank_ev),
    .tally_o (bank_tally),
    .where_o (bank_where)
  );

  // Working registers of the sequence.
  always_ff @(posedge clk_i) begin
    case (state_q)
      mmbt_pkg::S_EXEC: begin
        ev_q    <= ev_exec;
        clamp_q <= (func_cur == mmbt_pkg::FUNC_REPORT) ||
                   (func_cur == mmbt_pkg::FUNC_SET_POS);
        if ((func_cur == mmbt_pkg::FUNC_SET_POS) ||
            ((func_cur == mmbt_pkg::FUNC_REPORT) && abs_q && abs_moved)) begin
          pre_x_q <= {{(PW-CW){mx_q[CW-1]}}, mx_q};
          pre_y_q <= {{(PW-CW){my_q[CW-1]}}, my_q};
        end else begin
          pre_x_q <= {{(PW-CW){pos_x_q[CW-1]}}, pos_x_q};
          pre_y_q <= {{(PW-CW){pos_y_q[CW-1]}}, pos_y_q};
        end
      end
      mmbt_pkg::S_SQX: begin
        prod_q <= sq_op * sq_op;
      end
      mmbt_pkg::S_SQY: begin
        sum_q  <= {(QW-EW)'(0), energy_q} + prod_q;
        prod_q <= sq_op * sq_op;
      end
      mmbt_pkg::S_LIM: begin
        prod_q <= sq_op * sq_op;
      end
      mmbt_pkg::S_CMP: begin
        ty_q <= ty;
      end
      mmbt_pkg::S_DIVX: begin
        if (div_done) begin
          pre_x_q <= {{(PW-CW){pos_x_q[CW-1]}}, pos_x_q}
                   + {{(PW-TW){div_quo[TW-1]}}, div_quo};
        end
      end
      mmbt_pkg::S_DIVY: begin
        if (div_done) begin
          pre_y_q <= {{(PW-CW){pos_y_q[CW-1]}}, pos_y_q}
                   + {{(PW-TW){div_quo[TW-1]}}, div_quo};
        end
      end
      default: ;
    endcase
  end

  // Tracker state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q     <= mmbt_pkg::LEFT_RST;
      pos_y_q     <= mmbt_pkg::TOP_RST;
      rem_x_q     <= '0;
      rem_y_q     <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      prior_q     <= '0;
      tick_mark_q <= '0;
      energy_q    <= '0;
    end else begin
      case (state_q)
        mmbt_pkg::S_EXEC: begin
          if (func_cur == mmbt_pkg::FUNC_SET_POS) begin
            rem_x_q <= '0;
            rem_y_q <= '0;
            acc_x_q <= '0;
            acc_y_q <= '0;
          end else if ((func_cur == mmbt_pkg::FUNC_REPORT) && abs_q) begin
            if (abs_moved) begin
              acc_x_q <= acc_x_q + abs_dx;
              acc_y_q <= acc_y_q + abs_dy;
              rem_x_q <= '0;
              rem_y_q <= '0;
            end
          end else if ((func_cur == mmbt_pkg::FUNC_REPORT) && is_move &&
                       window_over) begin
            energy_q    <= '0;
            tick_mark_q <= tick_q;
          end
        end
        mmbt_pkg::S_LIM: begin
          // Energy saturates at all ones.
          energy_q <= (|energy_sum[QW-1:EW]) ? '1 : energy_sum[EW-1:0];
        end
        mmbt_pkg::S_CMP: begin
          acc_x_q <= acc_x_q + mx_eff[CW-1:0];
          acc_y_q <= acc_y_q + my_eff[CW-1:0];
        end
        mmbt_pkg::S_DIVX: begin
          if (div_done) rem_x_q <= div_rem;
        end
        mmbt_pkg::S_DIVY: begin
          if (div_done) rem_y_q <= div_rem;
        end
        mmbt_pkg::S_FINISH: begin
          if (fire) begin
            if (clamp_q) begin
              pos_x_q <= clamp_x;
              pos_y_q <= clamp_y;
            end
            if (func_cur == mmbt_pkg::FUNC_REPORT) prior_q <= btn_q;
            if (func_cur == mmbt_pkg::FUNC_RD_MOVE) begin
              acc_x_q <= '0;
              acc_y_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      event_bits_q <= events;
      notify_q     <= (events != '0);
      if (func_cur == mmbt_pkg::FUNC_REPORT) begin
        btn_state_q <= {wheel_bits, (CW-mmbt_pkg::WHEEL_W-mmbt_pkg::BTN_W)'(0), btn_q};
      end else begin
        btn_state_q <= {(CW-mmbt_pkg::BTN_W)'(0), prior_q};
      end
      cur_x_q    <= new_x;
      cur_y_q    <= new_y;
      motion_x_q <= acc_x_q;
      motion_y_q <= acc_y_q;
      if ((func_cur == mmbt_pkg::FUNC_RD_PRESS) || (func_cur == mmbt_pkg::FUNC_RD_REL)) begin
        tally_q <= bank_tally;
        at_x_q  <= bank_where[CW-1:0];
        at_y_q  <= bank_where[2*CW-1:CW];
      end else begin
        tally_q <= '0;
        at_x_q  <= '0;
        at_y_q  <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_bits_o    = event_bits_q;
  assign btn_state_out_o = btn_state_q;
  assign cur_x_o         = cur_x_q;
  assign cur_y_o         = cur_y_q;
  assign motion_x_o      = motion_x_q;
  assign motion_y_o      = motion_y_q;
  assign tally_o         = tally_q;
  assign at_x_o          = at_x_q;
  assign at_y_o          = at_y_q;
  assign notify_o        = notify_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `MMBT_ASSERT_IMPLY(a_div_idle_when_ready, in_ready_o, !div_busy, "divider busy while idle")
  `MMBT_ASSERT_IMPLY(a_div_done_in_wait, div_done,
    (state_q == mmbt_pkg::S_DIVX) || (state_q == mmbt_pkg::S_DIVY), "stray divider result")
  `MMBT_ASSERT_NEXT(a_result_then_idle, fire, out_valid_q && in_ready_o,
    "result not presented after completion")
  `MMBT_ASSERT_NEXT(a_accept_starts, in_fire, state_q == mmbt_pkg::S_EXEC,
    "accepted transaction not started")

endmodule

// ===== rtl/mmbt_divider.sv =====
// Signed by unsigned restoring divider, one quotient bit per cycle.
// Truncates towards zero; the remainder takes the sign of the dividend.
module mmbt_divider (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [mmbt_pkg::TERM_W-1:0]     dividend_i,
  input  logic        [mmbt_pkg::RATIO_W-1:0]    divisor_i,
  output logic                                   busy_o,
  output logic                                   done_o,
  output logic signed [mmbt_pkg::TERM_W-1:0]     quotient_o,
  output logic signed [mmbt_pkg::COORD_W-1:0]    remainder_o
);

  localparam int TW  = mmbt_pkg::TERM_W;
  localparam int RW  = mmbt_pkg::RATIO_W;
  localparam int CNT_W = $clog2(TW);

  logic             busy_q;
  logic             done_q;
  logic             neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [TW-1:0]    dvd_q;
  logic [RW-1:0]    dvs_q;
  logic [RW-1:0]    rem_q;

  logic [RW:0]      shifted;
  logic [RW:0]      diff;
  logic             qbit;
  logic [TW-1:0]    dvd_mag;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem_q, dvd_q[TW-1]};
    diff    = shifted - {1'b0, dvs_q};
    qbit    = (shifted >= {1'b0, dvs_q});
    dvd_mag = dividend_i[TW-1] ? (TW'(0) - dividend_i) : dividend_i;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(TW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(TW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Operand and partial result registers; the quotient shifts into dvd_q.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[TW-1];
      dvd_q <= dvd_mag;
      dvs_q <= (divisor_i == '0) ? RW'(1) : divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[TW-2:0], qbit};
      rem_q <= qbit ? diff[RW-1:0] : shifted[RW-1:0];
    end
  end

  // Restore the signs.
  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = neg_q ? (TW'(0) - dvd_q) : dvd_q;
  assign remainder_o = neg_q ? (mmbt_pkg::COORD_W'(0) - {1'b0, rem_q}) : {1'b0, rem_q};

endmodule

// ===== rtl/mmbt_button_bank.sv =====
// Press and release counters with the cursor position of the last counted
// edge, one pair for each button. A read returns the selected entry and
// clears it in the same transaction.
module mmbt_button_bank #(
  parameter int BUTTON_COUNT = mmbt_pkg::BUTTON_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mmbt_pkg::btn_ctl_t                  ctl_i,
  input  logic [mmbt_pkg::BTN_W-1:0]          btn_i,
  input  logic [mmbt_pkg::BTN_W-1:0]          prior_i,
  input  logic [mmbt_pkg::WHERE_W-1:0]        where_i,
  input  logic [mmbt_pkg::BTN_W-1:0]          sel_i,
  output logic [mmbt_pkg::BTN_EV_W-1:0]       ev_o,
  output logic [mmbt_pkg::COORD_W-1:0]        tally_o,
  output logic [mmbt_pkg::WHERE_W-1:0]        where_o
);

  localparam int SEL_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam int CW    = mmbt_pkg::COORD_W;
  localparam int WW    = mmbt_pkg::WHERE_W;

  logic [CW-1:0] press_cnt_q [BUTTON_COUNT];
  logic [WW-1:0] press_at_q  [BUTTON_COUNT];
  logic [CW-1:0] rel_cnt_q   [BUTTON_COUNT];
  logic [WW-1:0] rel_at_q    [BUTTON_COUNT];

  logic [BUTTON_COUNT-1:0] press_hit;
  logic [BUTTON_COUNT-1:0] rel_hit;
  logic [SEL_W-1:0]        idx;

  // Edge detection; buttons beyond the report's bits never change.
  for (genvar gi = 0; gi < BUTTON_COUNT; gi++) begin : g_edge
    if (gi < mmbt_pkg::BTN_W) begin : g_real
      assign press_hit[gi] = btn_i[gi] && !prior_i[gi];
      assign rel_hit[gi]   = !btn_i[gi] && prior_i[gi];
    end else begin : g_absent
      assign press_hit[gi] = 1'b0;
      assign rel_hit[gi]   = 1'b0;
    end
  end

  // Event bits: press and release of button i sit at 2i and 2i+1 here.
  for (genvar gi = 0; gi < mmbt_pkg::BTN_EV_W / 2; gi++) begin : g_ev
    if (gi < BUTTON_COUNT) begin : g_used
      assign ev_o[2*gi]   = ctl_i.upd && press_hit[gi];
      assign ev_o[2*gi+1] = ctl_i.upd && rel_hit[gi];
    end else begin : g_unused
      assign ev_o[2*gi]   = 1'b0;
      assign ev_o[2*gi+1] = 1'b0;
    end
  end

  // A selection beyond the last button reads the last button.
  always_comb begin
    if ({1'b0, sel_i} >= (mmbt_pkg::BTN_W + 1)'(BUTTON_COUNT)) begin
      idx = SEL_W'(BUTTON_COUNT - 1);
    end else begin
      idx = sel_i[SEL_W-1:0];
    end
  end

  // Read port for counter reads.
  assign tally_o = ctl_i.rd_rel ? rel_cnt_q[idx] : press_cnt_q[idx];
  assign where_o = ctl_i.rd_rel ? rel_at_q[idx]  : press_at_q[idx];

  // Counting on reports, clearing on reads.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        press_cnt_q[i] <= '0;
        press_at_q[i]  <= '0;
        rel_cnt_q[i]   <= '0;
        rel_at_q[i]    <= '0;
      end
    end else begin
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        if (ctl_i.upd && press_hit[i]) begin
          press_cnt_q[i] <= press_cnt_q[i] + 1'b1;
          press_at_q[i]  <= where_i;
        end else if (ctl_i.upd && rel_hit[i]) begin
          rel_cnt_q[i] <= rel_cnt_q[i] + 1'b1;
          rel_at_q[i]  <= where_i;
        end
        if (ctl_i.rd_press && (idx == SEL_W'(i))) begin
          press_cnt_q[i] <= '0;
          press_at_q[i]  <= '0;
        end
        if (ctl_i.rd_rel && (idx == SEL_W'(i))) begin
          rel_cnt_q[i] <= '0;
          rel_at_q[i]  <= '0;
        end
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mmbt_pkg::*;

  localparam int BUTTONS = BUTTON_COUNT_DEF;
  // Operation codes above the last defined one must leave the state alone.
  localparam logic [FUNC_W-1:0] FUNC_SPARE = FUNC_RD_MOVE + 1;
  localparam logic [FUNC_W-1:0] FUNC_TOP = '1;
  localparam int QUIET_LIMIT = 4000;
  localparam int RAND_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 204;
  localparam int SETTLE_CYCLES = 64;
  localparam int PRINT_LIMIT = 50;

  // One mouse report or host access.
  typedef struct {
    logic [FUNC_W-1:0]         func;
    logic [BTN_W-1:0]          btn;
    logic                      abs_mode;
    logic signed [COORD_W-1:0] move_x;
    logic signed [COORD_W-1:0] move_y;
    logic signed [WHEEL_W-1:0] wheel;
    logic [COORD_W-1:0]        tick;
    logic [BTN_W-1:0]          sel;
  } mouse_item_t;

  // One result transaction.
  typedef struct {
    logic [MASK_W-1:0]  events;
    logic [COORD_W-1:0] buttons;
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    logic [COORD_W-1:0] motion_x;
    logic [COORD_W-1:0] motion_y;
    logic [COORD_W-1:0] tally;
    logic [COORD_W-1:0] at_x;
    logic [COORD_W-1:0] at_y;
    logic               notify;
  } tracker_result_t;

  // Cursor and button tracking model with the queue of results it predicts.
  class tracker_scoreboard;
    int unsigned       ratio_x;
    int unsigned       ratio_y;
    int unsigned       accel_lim;
    shortint           left_e;
    shortint           right_e;
    shortint           top_e;
    shortint           bottom_e;
    logic [MASK_W-1:0] ev_mask;

    shortint            pos_x;
    shortint            pos_y;
    int                 rem_x;
    int                 rem_y;
    logic [COORD_W-1:0] acc_x;
    logic [COORD_W-1:0] acc_y;
    logic [BTN_W-1:0]   last_btn;
    logic [COORD_W-1:0] tick_mark;
    logic [31:0]        energy;
    logic [COORD_W-1:0] press_cnt [BUTTONS];
    logic [WHERE_W-1:0] press_at [BUTTONS];
    logic [COORD_W-1:0] release_cnt [BUTTONS];
    logic [WHERE_W-1:0] release_at [BUTTONS];

    tracker_result_t awaited[$];
    int              mismatches;
    int              checked;
    int              doubled_moves;

    function new();
      ratio_x = RATIO_X_RST;
      ratio_y = RATIO_Y_RST;
      accel_lim = LIMIT_RST;
      left_e = LEFT_RST;
      right_e = RIGHT_RST;
      top_e = TOP_RST;
      bottom_e = BOTTOM_RST;
      ev_mask = MASK_RST;
      pos_x = LEFT_RST;
      pos_y = TOP_RST;
      rem_x = 0;
      rem_y = 0;
      acc_x = '0;
      acc_y = '0;
      last_btn = '0;
      tick_mark = '0;
      energy = '0;
      for (int i = 0; i < BUTTONS; i++) begin
        press_cnt[i] = '0;
        press_at[i] = '0;
        release_cnt[i] = '0;
        release_at[i] = '0;
      end
      mismatches = 0;
      checked = 0;
      doubled_moves = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
      case (idx)
        CFG_RATIO_X: ratio_x = d[RATIO_W-1:0];
        CFG_RATIO_Y: ratio_y = d[RATIO_W-1:0];
        CFG_LIMIT:   accel_lim = d;
        CFG_LEFT:    left_e = d;
        CFG_RIGHT:   right_e = d;
        CFG_TOP:     top_e = d;
        CFG_BOTTOM:  bottom_e = d;
        CFG_MASK:    ev_mask = d[MASK_W-1:0];
        default: ;
      endcase
    endfunction

    // The minimum edge is applied first, so an inverted window ends at the maximum.
    function shortint clamp_to(int p, shortint lo, shortint hi);
      if (p < lo) p = lo;
      if (p > hi) p = hi;
      return shortint'(p);
    endfunction

    // Mickeys times eight over the ratio, carrying the remainder; ratio zero acts as one.
    function int scaled_step(int m, int unsigned ratio, inout int rem);
      int r;
      int t;
      int q;
      r = (ratio == 0) ? 1 : int'(ratio);
      t = m * (1 << SCALE_SHIFT) + rem;
      q = t / r;
      rem = t - q * r;
      return q;
    endfunction

    function void apply_report(mouse_item_t it, output logic [MASK_W-1:0] ev_out,
                               output logic [COORD_W-1:0] bst);
      logic [MASK_W-1:0]  ev;
      int                 mx;
      int                 my;
      int                 px;
      int                 py;
      int unsigned        mag_x;
      int unsigned        mag_y;
      logic [63:0]        e;
      logic [COORD_W-1:0] span;
      logic [WHERE_W-1:0] at;
      ev = '0;
      mx = it.move_x;
      my = it.move_y;
      px = pos_x;
      py = pos_y;
      if (it.abs_mode) begin
        // Absolute placement: the motion counters follow in mickeys of eight per pixel.
        ev[EV_ABS] = 1'b1;
        if (mx != px || my != py) begin
          ev[EV_MOVE] = 1'b1;
          acc_x = acc_x + COORD_W'((mx - px) * (1 << SCALE_SHIFT));
          acc_y = acc_y + COORD_W'((my - py) * (1 << SCALE_SHIFT));
          px = mx;
          py = my;
          rem_x = 0;
          rem_y = 0;
        end
      end else if (mx != 0 || my != 0) begin
        // Relative motion with speed doubling over the tick window.
        ev[EV_MOVE] = 1'b1;
        span = it.tick - tick_mark;
        if (span >= TICK_WINDOW) begin
          energy = '0;
          tick_mark = it.tick;
        end
        mag_x = (mx < 0) ? -mx : mx;
        mag_y = (my < 0) ? -my : my;
        e = 64'(energy) + 64'(mag_x) * 64'(mag_x) + 64'(mag_y) * 64'(mag_y);
        energy = (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
        if (64'(energy) > 64'(accel_lim) * 64'(accel_lim)) begin
          mx = mx * 2;
          my = my * 2;
          doubled_moves++;
        end
        acc_x = acc_x + COORD_W'(mx);
        acc_y = acc_y + COORD_W'(my);
        px = px + scaled_step(mx, ratio_x, rem_x);
        py = py + scaled_step(my, ratio_y, rem_y);
      end
      pos_x = clamp_to(px, left_e, right_e);
      pos_y = clamp_to(py, top_e, bottom_e);

      bst = COORD_W'(it.btn);
      if (WHEEL_PRESENT && it.wheel != 0) begin
        ev[EV_WHEEL] = 1'b1;
        bst[COORD_W-1:WHEEL_W] = it.wheel;
      end

      // Button edges: the press bit of button i sits below its release bit.
      at = {pos_y, pos_x};
      for (int i = 0; i < BUTTONS; i++) begin
        if (it.btn[i] && !last_btn[i]) begin
          ev[1 + 2 * i] = 1'b1;
          press_cnt[i] = press_cnt[i] + 1'b1;
          press_at[i] = at;
        end else if (!it.btn[i] && last_btn[i]) begin
          ev[2 + 2 * i] = 1'b1;
          release_cnt[i] = release_cnt[i] + 1'b1;
          release_at[i] = at;
        end
      end
      last_btn = it.btn;
      ev_out = ev & ev_mask;
    endfunction

    // Works out the result of an accepted transaction and queues it.
    function void note_input(mouse_item_t it);
      tracker_result_t    r;
      int                 s;
      logic [WHERE_W-1:0] at;
      s = (it.sel > BUTTONS - 1) ? BUTTONS - 1 : int'(it.sel);
      r.events = '0;
      r.buttons = COORD_W'(last_btn);
      r.tally = '0;
      at = '0;
      case (it.func)
        FUNC_REPORT: apply_report(it, r.events, r.buttons);
        FUNC_SET_POS: begin
          rem_x = 0;
          rem_y = 0;
          acc_x = '0;
          acc_y = '0;
          pos_x = clamp_to(it.move_x, left_e, right_e);
          pos_y = clamp_to(it.move_y, top_e, bottom_e);
        end
        FUNC_RD_PRESS: begin
          r.tally = press_cnt[s];
          at = press_at[s];
          press_cnt[s] = '0;
          press_at[s] = '0;
        end
        FUNC_RD_REL: begin
          r.tally = release_cnt[s];
          at = release_at[s];
          release_cnt[s] = '0;
          release_at[s] = '0;
        end
        default: ;
      endcase
      r.cur_x = pos_x;
      r.cur_y = pos_y;
      r.motion_x = acc_x;
      r.motion_y = acc_y;
      if (it.func == FUNC_RD_MOVE) begin
        acc_x = '0;
        acc_y = '0;
      end
      r.at_x = at[COORD_W-1:0];
      r.at_y = at[WHERE_W-1:COORD_W];
      r.notify = |r.events;
      awaited.push_back(r);
    endfunction

    task report_mismatch(string what, logic [COORD_W-1:0] got, logic [COORD_W-1:0] want);
      if (mismatches < PRINT_LIMIT)
        $display("%0t tb_top: mismatch on %s, got %h, want %h", $realtime, what, got, want);
      mismatches++;
    endtask

    task field_check(string what, logic [COORD_W-1:0] got, logic [COORD_W-1:0] want);
      if (got !== want) report_mismatch(what, got, want);
    endtask

    task check_result(tracker_result_t got);
      tracker_result_t want;
      if (awaited.size() == 0) begin
        report_mismatch("result with nothing outstanding", '0, '0);
      end else begin
        want = awaited.pop_front();
        checked++;
        field_check("event_bits", got.events, want.events);
        field_check("btn_state_out", got.buttons, want.buttons);
        field_check("cur_x", got.cur_x, want.cur_x);
        field_check("cur_y", got.cur_y, want.cur_y);
        field_check("motion_x", got.motion_x, want.motion_x);
        field_check("motion_y", got.motion_y, want.motion_y);
        field_check("tally", got.tally, want.tally);
        field_check("at_x", got.at_x, want.at_x);
        field_check("at_y", got.at_y, want.at_y);
        field_check("notify", got.notify, want.notify);
      end
    endtask
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i = '0;
  logic [CFG_W-1:0]          cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [FUNC_W-1:0]         func_i = '0;
  logic [BTN_W-1:0]          btn_in_i = '0;
  logic                      abs_mode_i = 1'b0;
  logic signed [COORD_W-1:0] move_x_i = '0;
  logic signed [COORD_W-1:0] move_y_i = '0;
  logic signed [WHEEL_W-1:0] wheel_step_i = '0;
  logic [COORD_W-1:0]        tick_now_i = '0;
  logic [BTN_W-1:0]          btn_select_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [MASK_W-1:0]         event_bits_o;
  logic [COORD_W-1:0]        btn_state_out_o;
  logic signed [COORD_W-1:0] cur_x_o;
  logic signed [COORD_W-1:0] cur_y_o;
  logic signed [COORD_W-1:0] motion_x_o;
  logic signed [COORD_W-1:0] motion_y_o;
  logic [COORD_W-1:0]        tally_o;
  logic signed [COORD_W-1:0] at_x_o;
  logic signed [COORD_W-1:0] at_y_o;
  logic                      notify_o;

  tracker_scoreboard  chk;
  int                 in_idle_pct = 0;
  int                 out_stall_pct = 0;
  int                 quiet_cycles = 0;
  int                 sent = 0;
  int                 cfg_writes = 0;
  logic [COORD_W-1:0] tick_clock;
  logic [BTN_W-1:0]   btn_hold;

  mouse_motion_button_tracker_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .btn_in_i       (btn_in_i),
    .abs_mode_i     (abs_mode_i),
    .move_x_i       (move_x_i),
    .move_y_i       (move_y_i),
    .wheel_step_i   (wheel_step_i),
    .tick_now_i     (tick_now_i),
    .btn_select_i   (btn_select_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_bits_o   (event_bits_o),
    .btn_state_out_o(btn_state_out_o),
    .cur_x_o        (cur_x_o),
    .cur_y_o        (cur_y_o),
    .motion_x_o     (motion_x_o),
    .motion_y_o     (motion_y_o),
    .tally_o        (tally_o),
    .at_x_o         (at_x_o),
    .at_y_o         (at_y_o),
    .notify_o       (notify_o)
  );

  // 50 MHz clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Result side: take a transaction when both handshake signals were high, then
  // decide the ready level for the next edge.
  always @(posedge clk_i) begin : take_result
    tracker_result_t seen;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        seen.events = event_bits_o;
        seen.buttons = btn_state_out_o;
        seen.cur_x = cur_x_o;
        seen.cur_y = cur_y_o;
        seen.motion_x = motion_x_o;
        seen.motion_y = motion_y_o;
        seen.tally = tally_o;
        seen.at_x = at_x_o;
        seen.at_y = at_y_o;
        seen.notify = notify_o;
        chk.check_result(seen);
      end
      out_ready_i <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Watchdog on cycles without any transaction on any channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t tb_top: watchdog expired with %0d results outstanding",
                 $realtime, chk.awaited.size());
        $display("tb_top: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one transaction, with random idle cycles ahead of it, and wait for acceptance.
  task automatic send_item(mouse_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= it.func;
    btn_in_i <= it.btn;
    abs_mode_i <= it.abs_mode;
    move_x_i <= it.move_x;
    move_y_i <= it.move_y;
    wheel_step_i <= it.wheel;
    tick_now_i <= it.tick;
    btn_select_i <= it.sel;
    do @(posedge clk_i); while (!in_ready_o);
    chk.note_input(it);
    sent++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    chk.write_reg(idx, data);
    cfg_writes++;
  endtask

  // Register settings: the reset values with all events enabled, the extremes,
  // a zero ratio with an inverted window, then random ones.
  task automatic apply_setting(int p);
    logic [CFG_W-1:0] vals [8];
    case (p)
      0: vals = '{16'd8, 16'd16, 16'd64, 16'd0, 16'd639, 16'd0, 16'd199, 16'h01FF};
      1: vals = '{16'd1, 16'd1, 16'd0, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h01FF};
      2: vals = '{16'h7FFF, 16'hFFFF, 16'hFFFF, CFG_W'(-100), 16'd100, CFG_W'(-50),
                  16'd50, 16'hFE00};
      3: vals = '{16'd0, 16'h8000, 16'd20, 16'd300, 16'd100, 16'd50, CFG_W'(-50),
                  CFG_W'($urandom)};
      7: foreach (vals[i]) vals[i] = $urandom;
      default: begin
        vals[0] = $urandom_range(40, 1) | (CFG_W'($urandom_range(1)) << RATIO_W);
        vals[1] = $urandom_range(40, 1);
        vals[2] = $urandom_range(300);
        vals[3] = -$urandom_range(400);
        vals[4] = $urandom_range(800);
        vals[5] = -$urandom_range(300);
        vals[6] = $urandom_range(500);
        vals[7] = $urandom;
      end
    endcase
    for (int i = 0; i < 8; i++) write_reg(cfg_idx_e'(i), vals[i]);
    cfg_valid_i <= 1'b0;
  endtask

  // Lets every outstanding result drain, then waits extra more quiet cycles.
  task automatic settle(int extra);
    in_valid_i <= 1'b0;
    while (chk.awaited.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  function automatic mouse_item_t mk(logic [FUNC_W-1:0] func, logic [BTN_W-1:0] btn,
                                     logic absm, int mx, int my, int wh, int tick,
                                     int sel);
    mouse_item_t it;
    it.func = func;
    it.btn = btn;
    it.abs_mode = absm;
    it.move_x = mx;
    it.move_y = my;
    it.wheel = wh;
    it.tick = tick;
    it.sel = sel;
    return it;
  endfunction

  function automatic int spread(int reach);
    return int'($urandom_range(2 * reach)) - reach;
  endfunction

  // Mostly well-formed reports with a steadily advancing tick and button history;
  // host accesses and unused codes carry random noise in the unused fields.
  function automatic mouse_item_t make_random_item();
    mouse_item_t it;
    int          pick;
    int          reach;
    it = mk(FUNC_REPORT, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom);
    pick = $urandom_range(99);
    if (pick < 5) begin
      it.func = FUNC_SET_POS;
      if ($urandom_range(1)) begin
        it.move_x = spread(1000);
        it.move_y = spread(1000);
      end
    end else if (pick < 10) begin
      it.func = FUNC_RD_PRESS;
    end else if (pick < 15) begin
      it.func = FUNC_RD_REL;
    end else if (pick < 19) begin
      it.func = FUNC_RD_MOVE;
    end else if (pick < 21) begin
      it.func = $urandom_range(FUNC_TOP, FUNC_SPARE);
    end else begin
      pick = $urandom_range(99);
      if (pick < 70) tick_clock = tick_clock + $urandom_range(2);
      else if (pick < 90) tick_clock = tick_clock + $urandom_range(25, 3);
      else tick_clock = $urandom;
      it.tick = tick_clock;
      if ($urandom_range(9) == 0) btn_hold = $urandom;
      else
        for (int i = 0; i < BTN_W; i++)
          if ($urandom_range(3) == 0) btn_hold[i] = ~btn_hold[i];
      it.btn = btn_hold;
      if ($urandom_range(9) < 7) it.wheel = '0;
      it.abs_mode = ($urandom_range(99) < 15);
      if (it.abs_mode) begin
        if ($urandom_range(9) < 3) begin
          it.move_x = chk.pos_x;
          it.move_y = chk.pos_y;
        end else if ($urandom_range(9) < 8) begin
          it.move_x = spread(700);
          it.move_y = spread(700);
        end
      end else begin
        pick = $urandom_range(99);
        reach = (pick < 63) ? 15 : (pick < 88) ? 400 : 0;
        if (pick < 8) begin
          it.move_x = '0;
          it.move_y = '0;
        end else if (reach != 0) begin
          it.move_x = spread(reach);
          it.move_y = spread(reach);
        end
        if ($urandom_range(9) == 0) it.move_x = '0;
        else if ($urandom_range(9) == 0) it.move_y = '0;
      end
    end
    return it;
  endfunction

  // Stimulus sequence.
  initial begin
    chk = new();
    tick_clock = $urandom;
    btn_hold = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: field extremes, every operation and the corner cases.
    apply_setting(0);
    send_item(mk(FUNC_REPORT, 3'b000, 1'b0, 5, 3, 0, 0, 0));
    send_item(mk(FUNC_REPORT, 3'b001, 1'b0, 32767, -32768, 0, 1, 0));
    send_item(mk(FUNC_REPORT, 3'b011, 1'b0, -32768, -32768, 0, 2, 0));
    send_item(mk(FUNC_REPORT, 3'b111, 1'b0, 0, 0, 127, 3, 0));
    send_item(mk(FUNC_REPORT, 3'b000, 1'b0, 0, 0, -128, 4, 0));
    send_item(mk(FUNC_REPORT, 3'b101, 1'b1, 100, 50, 0, 5, 0));
    send_item(mk(FUNC_REPORT, 3'b101, 1'b1, 100, 50, 1, 6, 0));
    send_item(mk(FUNC_REPORT, 3'b000, 1'b1, -32768, 32767, 0, 7, 0));
    send_item(mk(FUNC_REPORT, 3'b000, 1'b0, 1, 1, 0, 16'hFFFF, 0));
    send_item(mk(FUNC_REPORT, 3'b000, 1'b0, -1, -1, 0, 3, 0));
    send_item(mk(FUNC_RD_PRESS, 3'b000, 1'b0, 0, 0, 0, 0, 0));
    send_item(mk(FUNC_RD_PRESS, 3'b111, 1'b1, -1, -1, -1, 16'hFFFF, 7));
    send_item(mk(FUNC_RD_REL, 3'b000, 1'b0, 0, 0, 0, 0, 1));
    send_item(mk(FUNC_RD_REL, 3'b000, 1'b0, 0, 0, 0, 0, 2));
    send_item(mk(FUNC_RD_PRESS, 3'b000, 1'b0, 0, 0, 0, 0, 2));
    send_item(mk(FUNC_RD_MOVE, 3'b000, 1'b0, 0, 0, 0, 0, 0));
    send_item(mk(FUNC_RD_MOVE, 3'b000, 1'b0, 0, 0, 0, 0, 0));
    send_item(mk(FUNC_SET_POS, 3'b000, 1'b0, -32768, 32767, 0, 0, 0));
    send_item(mk(FUNC_SET_POS, 3'b000, 1'b0, 320, 100, 0, 0, 0));
    send_item(mk(FUNC_SPARE, 3'b111, 1'b1, 7, 7, 7, 7, 7));
    send_item(mk(FUNC_TOP, 3'b000, 1'b0, 0, 0, 0, 0, 0));
    send_item(mk(FUNC_REPORT, 3'b111, 1'b0, 32767, 32767, 127, 16'hFFFF, 7));
    send_item(mk(FUNC_REPORT, 3'b010, 1'b0, -3, 4, -1, 16'h0005, 0));
    settle(8);

    // Random phases, each under its own register setting, cycling through four idling patterns.
    for (int p = 1; p <= RAND_PHASES; p++) begin
      case ((p - 1) % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 82; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 82; end
        default: begin in_idle_pct = 37; out_stall_pct = 37; end
      endcase
      apply_setting(p);
      repeat (ITEMS_PER_PHASE) send_item(make_random_item());
      settle(8);
    end

    in_idle_pct = 0;
    out_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("tb_top: %0d transactions, %0d results compared, %0d register writes",
             sent, chk.checked, cfg_writes);
    $display("tb_top: %0d register settings, %0d accelerated moves, %0d mismatches",
             RAND_PHASES + 1, chk.doubled_moves, chk.mismatches);
    if (chk.mismatches == 0 && chk.awaited.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
